@@ hw/rtl/ehp_pkg.sv @@
// ============================================================================
// ehp_pkg
// Shared types and constants of the Ethernet / IPv4 / L4 header parser.
// ============================================================================
package ehp_pkg;

    // Frame byte counter
    localparam int unsigned CNT_W           = 16;
    localparam int unsigned MAX_FRAME_BYTES = 65535;

    // Header offsets and minimum sizes, in bytes
    localparam logic [4:0] ETH_HDR_BYTES      = 5'd14;
    localparam logic [4:0] VLAN_ETH_HDR_BYTES = 5'd18;
    localparam logic [5:0] IP_MIN_HDR_BYTES   = 6'd20;
    localparam logic [5:0] TCP_MIN_HDR_BYTES  = 6'd20;
    localparam logic [5:0] UDP_HDR_BYTES      = 6'd8;

    // Protocol codes
    localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;

    // Deepest layer codes
    localparam logic [2:0] LAYER_NONE = 3'd0;
    localparam logic [2:0] LAYER_ETH  = 3'd1;
    localparam logic [2:0] LAYER_IPV4 = 3'd2;
    localparam logic [2:0] LAYER_TCP  = 3'd3;
    localparam logic [2:0] LAYER_UDP  = 3'd4;

    // Header fields captured while a frame passes
    typedef struct packed {
        logic        vlan;
        logic [15:0] ether_type;
        logic [5:0]  ihl_bytes;
        logic [12:0] frag_offset;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [5:0]  data_offset;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  flag_bits;
    } hdr_fields_t;

    // One parse result
    typedef struct packed {
        logic        parse_ok;
        logic [2:0]  deepest_layer;
        logic [15:0] ether_type;
        logic [7:0]  ip_ttl;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  tcp_flag_byte;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
    } parse_result_t;

endpackage

@@ hw/rtl/ethernet_ipv4_l4_header_parser.sv @@
// ============================================================================
// ethernet_ipv4_l4_header_parser
// Streaming Ethernet / 802.1Q / IPv4 / TCP-UDP header parser.
// ============================================================================
// Usage:
//   Frame bytes enter on the s_ channel, one byte per transaction, in wire
//   order; s_tlast marks the final byte and so fixes the frame length.
//   For each frame one result transaction leaves on the m_ channel: parse
//   status and deepest layer in m_tuser, captured header fields, payload
//   offset and payload length in m_tdata. Bytes that are not last give no
//   result.
//   With the result slot free, a taken last byte passes the input register,
//   then the result register, before m_tvalid rises. Throughput: one byte
//   per cycle while the result slot is free, sustained across frame
//   boundaries; the capture logic and the end of frame checks both fit in
//   the single stage between the two registers.
//   If the receiver stalls, the result holds in the output register; bytes
//   that are not last keep flowing, and the next last byte waits in the
//   input register until the result slot frees up.
//   Reset clears the byte counter, all captured fields and both valid flags.
// ============================================================================
module ethernet_ipv4_l4_header_parser (
    input  logic         aclk,
    input  logic         aresetn,
    // Input byte stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // last_byte
    // Parse results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // [15:0] ether_type, [23:16] ip_ttl,
                                    // [31:24] ip_protocol, [63:32] source_address,
                                    // [95:64] dest_address, [111:96] source_port,
                                    // [127:112] dest_port, [135:128] tcp_flag_byte,
                                    // [151:136] payload_offset,
                                    // [167:152] payload_length
    output logic [3:0]   m_tuser    // [0] parse_ok, [3:1] deepest_layer
);
    import ehp_pkg::*;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;
    logic          out_free;
    logic          advance;
    logic          load_result;
    hdr_fields_t   fields_next;
    logic [15:0]   frame_len;
    parse_result_t result;
    parse_result_t res_reg;
    logic          m_valid_reg;

    // Pipeline control: a last byte needs a free result slot
    assign out_free    = !m_valid_reg || m_tready;
    assign advance     = in_valid_reg && (!in_last_reg || out_free);
    assign load_result = advance && in_last_reg;
    assign s_tready    = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Field capture and byte counting
    ehp_capture u_capture (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .data_byte   (in_byte_reg),
        .last_byte   (in_last_reg),
        .fields_next (fields_next),
        .frame_len   (frame_len)
    );

    // End of frame checks
    ehp_decide u_decide (
        .fields    (fields_next),
        .frame_len (frame_len),
        .result    (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_result) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {res_reg.deepest_layer, res_reg.parse_ok};
    assign m_tdata  = {res_reg.payload_length, res_reg.payload_offset,
                       res_reg.tcp_flag_byte, res_reg.dest_port, res_reg.source_port,
                       res_reg.dest_address, res_reg.source_address,
                       res_reg.ip_protocol, res_reg.ip_ttl, res_reg.ether_type};

`ifndef SYNTH
    // A new result only follows a last byte that was taken
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(in_valid_reg && in_last_reg))
        else $error("result appeared without a last byte");

    // Bytes that are not last never wait in the input register
    a_mid_byte_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_last_reg) |-> advance)
        else $error("mid-frame byte stalled");

    // A malformed frame never reaches past the Ethernet layer
    a_bad_layer: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !res_reg.parse_ok) |->
            (res_reg.deepest_layer == LAYER_NONE || res_reg.deepest_layer == LAYER_ETH))
        else $error("malformed frame reports an upper layer");

    // No layer means no captured fields
    a_none_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.deepest_layer == LAYER_NONE) |->
            (res_reg.ether_type == 16'd0 && res_reg.payload_length == 16'd0))
        else $error("short frame reports header fields");
`endif

endmodule

@@ hw/rtl/ehp_capture.sv @@
// ============================================================================
// ehp_capture
// Byte counter and header field capture; gives the fields as they stand
// after the current byte, and clears itself at the end of each frame.
// ============================================================================
module ehp_capture (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output ehp_pkg::hdr_fields_t fields_next,
    output logic [15:0]          frame_len
);
    import ehp_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    hdr_fields_t      fields_reg;
    logic [4:0]       ip_off;
    logic [CNT_W-1:0] ip_rel;
    logic [CNT_W-1:0] l4_rel;
    logic [CNT_W:0]   pos_plus1;

    // Locate the current byte relative to the IPv4 and L4 headers
    always_comb begin
        ip_off = fields_reg.vlan ? VLAN_ETH_HDR_BYTES : ETH_HDR_BYTES;
        ip_rel = cnt_reg - {{(CNT_W-5){1'b0}}, ip_off};
        l4_rel = ip_rel - {{(CNT_W-6){1'b0}}, fields_reg.ihl_bytes};
    end

    // Capture header bytes as their positions pass
    always_comb begin
        fields_next = fields_reg;
        if (cnt_reg == CNT_W'(12)) begin
            fields_next.ether_type = {data_byte, 8'h00};
        end
        if (cnt_reg == CNT_W'(13)) begin
            fields_next.ether_type = {fields_reg.ether_type[15:8], data_byte};
            fields_next.vlan = ({fields_reg.ether_type[15:8], data_byte} == ETH_TYPE_VLAN);
        end
        if (fields_reg.vlan && cnt_reg == CNT_W'(16)) begin
            fields_next.ether_type = {data_byte, 8'h00};
        end
        if (fields_reg.vlan && cnt_reg == CNT_W'(17)) begin
            fields_next.ether_type = {fields_reg.ether_type[15:8], data_byte};
        end
        if (cnt_reg >= {{(CNT_W-5){1'b0}}, ip_off}) begin
            // IPv4 header
            if (ip_rel == CNT_W'(0)) begin
                fields_next.ihl_bytes = {data_byte[3:0], 2'b00};
            end else if (ip_rel == CNT_W'(6)) begin
                fields_next.frag_offset = {data_byte[4:0], 8'h00};
            end else if (ip_rel == CNT_W'(7)) begin
                fields_next.frag_offset = {fields_reg.frag_offset[12:8], data_byte};
            end else if (ip_rel == CNT_W'(8)) begin
                fields_next.ttl = data_byte;
            end else if (ip_rel == CNT_W'(9)) begin
                fields_next.protocol = data_byte;
            end else if (ip_rel >= CNT_W'(12) && ip_rel <= CNT_W'(15)) begin
                fields_next.src_addr = {fields_reg.src_addr[23:0], data_byte};
            end else if (ip_rel >= CNT_W'(16) && ip_rel <= CNT_W'(19)) begin
                fields_next.dst_addr = {fields_reg.dst_addr[23:0], data_byte};
            end
            // L4 header, after the IPv4 options
            if (ip_rel >= CNT_W'(20) &&
                ip_rel >= {{(CNT_W-6){1'b0}}, fields_reg.ihl_bytes}) begin
                if (l4_rel == CNT_W'(0)) begin
                    fields_next.sport = {data_byte, 8'h00};
                end else if (l4_rel == CNT_W'(1)) begin
                    fields_next.sport = {fields_reg.sport[15:8], data_byte};
                end else if (l4_rel == CNT_W'(2)) begin
                    fields_next.dport = {data_byte, 8'h00};
                end else if (l4_rel == CNT_W'(3)) begin
                    fields_next.dport = {fields_reg.dport[15:8], data_byte};
                end else if (l4_rel == CNT_W'(12)) begin
                    fields_next.data_offset = {data_byte[7:4], 2'b00};
                end else if (l4_rel == CNT_W'(13)) begin
                    fields_next.flag_bits = data_byte;
                end
            end
        end
    end

    // Saturating count and frame length including the current byte
    always_comb begin
        pos_plus1 = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, 1'b1};
        if (cnt_reg < CNT_W'(MAX_FRAME_BYTES)) begin
            cnt_next  = pos_plus1[CNT_W-1:0];
            frame_len = pos_plus1[15:0];
        end else begin
            cnt_next  = cnt_reg;
            frame_len = 16'(MAX_FRAME_BYTES);
        end
    end

    // Advance on each byte, clear at the end of a frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            fields_reg <= '0;
        end else if (advance) begin
            if (last_byte) begin
                cnt_reg    <= '0;
                fields_reg <= '0;
            end else begin
                cnt_reg    <= cnt_next;
                fields_reg <= fields_next;
            end
        end
    end

endmodule

@@ hw/rtl/ehp_decide.sv @@
// ============================================================================
// ehp_decide
// Length and header checks at the end of a frame; builds the result.
// ============================================================================
module ehp_decide (
    input  ehp_pkg::hdr_fields_t   fields,
    input  logic [15:0]            frame_len,
    output ehp_pkg::parse_result_t result
);
    import ehp_pkg::*;

    logic [4:0]  ip_off;
    logic [6:0]  l4_off;
    logic [15:0] seg_len;
    logic [15:0] tcp_pay_len;
    logic [15:0] udp_pay_len;

    // Header boundaries
    always_comb begin
        ip_off      = fields.vlan ? VLAN_ETH_HDR_BYTES : ETH_HDR_BYTES;
        l4_off      = {2'b00, ip_off} + {1'b0, fields.ihl_bytes};
        seg_len     = frame_len - {9'd0, l4_off};
        tcp_pay_len = seg_len - {10'd0, fields.data_offset};
        udp_pay_len = seg_len - {10'd0, UDP_HDR_BYTES};
    end

    // Walk down the layers while the checks pass
    always_comb begin
        result = '0;
        if (frame_len >= {11'd0, ip_off}) begin
            result.deepest_layer = LAYER_ETH;
            result.ether_type    = fields.ether_type;
            if (fields.ether_type != ETH_TYPE_IPV4) begin
                result.parse_ok = 1'b1;
            end else if (frame_len >= {11'd0, ip_off} + {10'd0, IP_MIN_HDR_BYTES} &&
                         fields.ihl_bytes >= IP_MIN_HDR_BYTES &&
                         frame_len >= {9'd0, l4_off}) begin
                result.parse_ok       = 1'b1;
                result.deepest_layer  = LAYER_IPV4;
                result.ip_ttl         = fields.ttl;
                result.ip_protocol    = fields.protocol;
                result.source_address = fields.src_addr;
                result.dest_address   = fields.dst_addr;
                if (fields.frag_offset == 13'd0) begin
                    if (fields.protocol == IP_PROTO_TCP) begin
                        if (seg_len >= {10'd0, TCP_MIN_HDR_BYTES} &&
                            fields.data_offset >= TCP_MIN_HDR_BYTES &&
                            seg_len >= {10'd0, fields.data_offset}) begin
                            result.deepest_layer  = LAYER_TCP;
                            result.source_port    = fields.sport;
                            result.dest_port      = fields.dport;
                            result.tcp_flag_byte  = fields.flag_bits;
                            result.payload_offset = {9'd0, l4_off} +
                                                    {10'd0, fields.data_offset};
                            result.payload_length = tcp_pay_len;
                        end
                    end else if (fields.protocol == IP_PROTO_UDP) begin
                        if (seg_len >= {10'd0, UDP_HDR_BYTES}) begin
                            result.deepest_layer  = LAYER_UDP;
                            result.source_port    = fields.sport;
                            result.dest_port      = fields.dport;
                            result.payload_offset = {9'd0, l4_off} +
                                                    {10'd0, UDP_HDR_BYTES};
                            result.payload_length = udp_pay_len;
                        end
                    end
                end
            end
        end
    end

endmodule
